>>> design/uule_pkg.sv
// shared types, constants and character mapping for the uuencode line encoder
`timescale 1ns / 1ps
`default_nettype none

package uule_pkg;

    localparam int LINE_BYTES_DEF = 45;

    localparam logic [6:0] CHAR_OFFSET = 7'd32;
    localparam logic [6:0] CHAR_ZERO   = 7'd96;

    // one encoded character with its markers
    typedef struct packed {
        logic [6:0] ch;
        logic       eol;
        logic       eot;
        logic       last;
    } uule_char_t;

    function automatic logic [6:0] enc6(input logic [5:0] v);
        logic [6:0] r;
        if (v == 6'd0)
        begin
            r = CHAR_ZERO;
        end
        else
        begin
            r = {1'b0, v} + CHAR_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/uule_out_stage.sv
// output register for encoded characters, decouples the encoder from the receiver
`timescale 1ns / 1ps
`default_nettype none

module uule_out_stage
    import uule_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire uule_char_t load_char,
    output logic            slot_free,
    output logic            char_valid,
    input  wire logic       char_stall,
    output logic [6:0]      out_char,
    output logic            end_of_line,
    output logic            end_of_text,
    output logic            last_of_run
);

    logic       valid_reg;
    logic       valid_next;
    uule_char_t char_reg;

    assign slot_free  = !valid_reg || !char_stall;
    assign valid_next = load ? 1'b1 : (valid_reg && char_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= load_char;
        end
    end

    assign char_valid  = valid_reg;
    assign out_char    = char_reg.ch;
    assign end_of_line = char_reg.eol;
    assign end_of_text = char_reg.eot;
    assign last_of_run = char_reg.last;

    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> slot_free)
        else $error("character loaded while output register is held");

    a_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && char_stall |=> valid_reg)
        else $error("stalled character dropped");

endmodule

`default_nettype wire

>>> design/uuencode_line_encoder_core.sv
// top level of the uuencode line encoder: line store, sequencer and output register
// usage:
//   input channel (data_byte, byte_valid, end_of_file) with data_valid / data_stall.
//   a transaction with byte_valid set stores one byte in the line store; when the
//   store reaches LINE_BYTES bytes, or when end_of_file is set, the line is sent on
//   the output channel (out_char, end_of_line, end_of_text, last_of_run) with
//   char_valid / char_stall, one character per transaction: length character,
//   four characters per group of three bytes, end_of_line on the last one.
//   end_of_file adds the terminating line: one backquote with end_of_text set.
//   last_of_run marks the final character caused by one input transaction.
// sending:
//   while a line is sent the input is stalled: the length character is sent,
//   then per group the line store is read and captured (one read port) and the
//   four characters are sent, plus a terminator after the last line of a text.
//   the output register lets the next input transaction be taken while the
//   last character still waits; a receiver stall holds the character and
//   pauses the sequencer.
// reset: clears the fill count, the sequencer and the output valid; line store
//   contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module uuencode_line_encoder_core
    import uule_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       data_valid,
    output logic            data_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       byte_valid,
    input  wire logic       end_of_file,
    output logic            char_valid,
    input  wire logic       char_stall,
    output logic [6:0]      out_char,
    output logic            end_of_line,
    output logic            end_of_text,
    output logic            last_of_run
);

    localparam int ADDR_W = $clog2(LINE_BYTES);
    localparam int CNT_W  = $clog2(LINE_BYTES + 1);
    localparam int IDX_W  = $clog2(LINE_BYTES + 3);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LEN  = 5'b00010,
        S_RD   = 5'b00100,
        S_CHR  = 5'b01000,
        S_TERM = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic               eof_reg, eof_next;
    logic [IDX_W-1:0]   base_reg, base_next;
    logic [1:0]         phase_reg, phase_next;
    logic [1:0]         chr_reg, chr_next;
    logic [23:0]        grp_reg, grp_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               rd_keep_reg, rd_keep_next;
    logic [7:0]         rd_data_reg;

    logic [7:0]         line_mem [LINE_BYTES];

    logic               data_fire;
    logic               wr_en;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    logic               rd_in_range;
    logic [CNT_W-1:0]   cnt_inc;
    logic               last_group;
    logic               slot_free;
    logic               emit;
    uule_char_t         emit_char;
    logic [5:0]         chr_val;

    assign data_stall  = (state_reg != S_IDLE);
    assign data_fire   = data_valid && !data_stall;
    assign wr_en       = data_fire && byte_valid;
    assign cnt_inc     = fill_reg + CNT_W'(1);

    assign rd_idx      = base_reg + IDX_W'(phase_reg);
    assign rd_in_range = rd_idx < IDX_W'(len_reg);
    assign rd_en       = (state_reg == S_RD) && (phase_reg != 2'd3) && rd_in_range;
    assign last_group  = (base_reg + IDX_W'(3)) >= IDX_W'(len_reg);

    always_comb
    begin
        case (chr_reg)
            2'd0:    chr_val = grp_reg[23:18];
            2'd1:    chr_val = grp_reg[17:12];
            2'd2:    chr_val = grp_reg[11:6];
            default: chr_val = grp_reg[5:0];
        endcase
    end

    // line store: byte writes from the input, group reads while sending
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[fill_reg[ADDR_W-1:0]] <= data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_idx[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        len_next     = len_reg;
        eof_next     = eof_reg;
        base_next    = base_reg;
        phase_next   = phase_reg;
        chr_next     = chr_reg;
        grp_next     = grp_reg;
        rd_pend_next = (state_reg == S_RD) && (phase_reg != 2'd3);
        rd_keep_next = rd_in_range;
        emit         = 1'b0;
        emit_char    = '{ch: CHAR_ZERO, eol: 1'b0, eot: 1'b0, last: 1'b0};

        // bytes past the line length read as zero
        if (rd_pend_reg)
        begin
            grp_next = {grp_reg[15:0], (rd_keep_reg ? rd_data_reg : 8'd0)};
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (data_fire)
                begin
                    eof_next  = end_of_file;
                    base_next = '0;
                    if (byte_valid && (cnt_inc == CNT_W'(LINE_BYTES)))
                    begin
                        len_next   = cnt_inc;
                        fill_next  = '0;
                        state_next = S_LEN;
                    end
                    else if (end_of_file)
                    begin
                        fill_next = '0;
                        if (byte_valid || (fill_reg != '0))
                        begin
                            len_next   = byte_valid ? cnt_inc : fill_reg;
                            state_next = S_LEN;
                        end
                        else
                        begin
                            state_next = S_TERM;
                        end
                    end
                    else if (byte_valid)
                    begin
                        fill_next = cnt_inc;
                    end
                end
            end
            S_LEN:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_char.ch = enc6(6'(len_reg));
                    phase_next = 2'd0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    chr_next   = 2'd0;
                    state_next = S_CHR;
                end
            end
            S_CHR:
            begin
                if (slot_free)
                begin
                    emit           = 1'b1;
                    emit_char.ch   = enc6(chr_val);
                    emit_char.eol  = (chr_reg == 2'd3) && last_group;
                    emit_char.last = (chr_reg == 2'd3) && last_group && !eof_reg;
                    chr_next       = chr_reg + 2'd1;
                    if (chr_reg == 2'd3)
                    begin
                        if (!last_group)
                        begin
                            base_next  = base_reg + IDX_W'(3);
                            phase_next = 2'd0;
                            state_next = S_RD;
                        end
                        else if (eof_reg)
                        begin
                            state_next = S_TERM;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_TERM:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_char  = '{ch: CHAR_ZERO, eol: 1'b1, eot: 1'b1, last: 1'b1};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            eof_reg     <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            eof_reg     <= eof_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        base_reg    <= base_next;
        phase_reg   <= phase_next;
        chr_reg     <= chr_next;
        grp_reg     <= grp_next;
        rd_keep_reg <= rd_keep_next;
    end

    uule_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (emit),
        .load_char   (emit_char),
        .slot_free   (slot_free),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .out_char    (out_char),
        .end_of_line (end_of_line),
        .end_of_text (end_of_text),
        .last_of_run (last_of_run)
    );

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < CNT_W'(LINE_BYTES))
        else $error("fill count reached line size without sending the line");

    a_full_line_sent: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && (cnt_inc == CNT_W'(LINE_BYTES)) |=> (state_reg == S_LEN))
        else $error("full line did not start sending");

    a_eof_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        data_fire && end_of_file |=> (state_reg != S_IDLE) && (fill_reg == '0))
        else $error("end of file did not flush the line store");

    a_capture_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> $past(state_reg == S_RD))
        else $error("line store capture outside a read sequence");

    a_line_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEN) || (state_reg == S_RD) || (state_reg == S_CHR)
        |-> (len_reg != '0))
        else $error("sending a line of length zero");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for the uuencode line encoder core
`timescale 1ns / 1ps

module testbench;
    import uule_pkg::*;

    localparam int LINE_LEN = LINE_BYTES_DEF;

    typedef struct {
        logic [6:0] ch;
        logic       eol;
        logic       eot;
        logic       last;
    } enc_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       data_valid = 1'b0;
    logic       data_stall;
    logic [7:0] data_byte = 8'h00;
    logic       byte_valid = 1'b0;
    logic       end_of_file = 1'b0;
    logic       char_valid;
    logic       char_stall = 1'b0;
    logic [6:0] out_char;
    logic       end_of_line;
    logic       end_of_text;
    logic       last_of_run;

    // predictor state
    logic [7:0] line_bytes [0:LINE_LEN-1];
    int         line_fill = 0;
    enc_char_t  expected_chars [$];

    int mismatches = 0;
    int chars_checked = 0;
    int lines_seen = 0;
    int texts_ended = 0;
    int items_sent = 0;
    int burst_left = 0;
    bit steady = 1'b0;
    int stall_cycle = 0;
    int stall_mode = 0;

    uuencode_line_encoder_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_valid  (data_valid),
        .data_stall  (data_stall),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .end_of_file (end_of_file),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .out_char    (out_char),
        .end_of_line (end_of_line),
        .end_of_text (end_of_text),
        .last_of_run (last_of_run)
    );

    always #5 clk = ~clk;

    function automatic logic [6:0] printable(input logic [5:0] v);
        if (v == 6'd0)
        begin
            return CHAR_ZERO;
        end
        return {1'b0, v} + CHAR_OFFSET;
    endfunction

    function automatic logic [7:0] stored_byte(input int idx, input int len);
        if (idx >= len)
        begin
            return 8'h00;
        end
        return line_bytes[idx];
    endfunction

    // one encoded line appended to the chars of the current transaction
    task automatic encode_line(input int len, ref enc_char_t run [$]);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic       tail;
        if (len == 0)
        begin
            run.push_back('{printable(6'd0), 1'b1, 1'b1, 1'b0});
            return;
        end
        run.push_back('{printable(len[5:0]), 1'b0, 1'b0, 1'b0});
        for (int i = 0; i < len; i += 3)
        begin
            a = stored_byte(i, len);
            b = stored_byte(i + 1, len);
            c = stored_byte(i + 2, len);
            tail = (i + 3 >= len);
            run.push_back('{printable(a[7:2]), 1'b0, 1'b0, 1'b0});
            run.push_back('{printable({a[1:0], b[7:4]}), 1'b0, 1'b0, 1'b0});
            run.push_back('{printable({b[3:0], c[7:6]}), 1'b0, 1'b0, 1'b0});
            run.push_back('{printable(c[5:0]), tail, 1'b0, 1'b0});
        end
    endtask

    task automatic encode_item(input logic [7:0] b, input logic bv, input logic eof);
        enc_char_t run [$];
        if (bv)
        begin
            line_bytes[line_fill] = b;
            line_fill++;
            if (line_fill == LINE_LEN)
            begin
                encode_line(LINE_LEN, run);
                line_fill = 0;
            end
        end
        if (eof)
        begin
            if (line_fill > 0)
            begin
                encode_line(line_fill, run);
                line_fill = 0;
            end
            encode_line(0, run);
        end
        if (run.size() > 0)
        begin
            run[run.size() - 1].last = 1'b1;
        end
        foreach (run[i])
        begin
            expected_chars.push_back(run[i]);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 20)
        begin
            $display("%0t: char %0d %s: got %0d expected %0d",
                     $realtime, chars_checked, what, got, want);
        end
        mismatches++;
    endtask

    // bursts of random length, random gaps between them, none while steady
    task automatic pace_sender();
        if (steady)
        begin
            return;
        end
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        data_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        burst_left = $urandom_range(0, 12);
    endtask

    task automatic send_item(input logic [7:0] b, input logic bv, input logic eof);
        data_byte   <= b;
        byte_valid  <= bv;
        end_of_file <= eof;
        data_valid  <= 1'b1;
        @(posedge clk);
        while (data_stall)
        begin
            @(posedge clk);
        end
        encode_item(b, bv, eof);
        items_sent++;
        pace_sender();
    endtask

    task automatic drain_outputs();
        data_valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // one text of n bytes; the end mark rides on the last byte or comes bare
    task automatic send_text(input int n, input bit eof_on_last, input bit noisy);
        for (int i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 7) == 0)
            begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_item(8'($urandom), 1'b1, eof_on_last && (i == n - 1));
        end
        if (!eof_on_last || n == 0)
        begin
            send_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic test_terminator_only();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
    endtask

    task automatic test_short_lines();
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'hFC, 1'b1, 1'b0);
        send_item(8'h03, 1'b1, 1'b0);
        send_item(8'h0F, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'hAA, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b1);
    endtask

    // full line closed by the end mark, full line then bare mark, two lines
    task automatic test_line_boundaries();
        steady = 1'b1;
        send_text(LINE_LEN, 1'b1, 1'b0);
        steady = 1'b0;
        send_text(LINE_LEN, 1'b0, 1'b0);
        drain_outputs();
        send_text(2 * LINE_LEN, 1'b1, 1'b1);
    endtask

    task automatic test_random_texts();
        int n;
        int sent;
        bit drained;
        sent = 0;
        drained = 1'b0;
        while (sent < 60)
        begin
            case ($urandom_range(0, 9)) inside
                0:       n = 0;
                [1:3]:   n = $urandom_range(1, 8);
                [4:5]:   n = $urandom_range(9, LINE_LEN - 1);
                6:       n = LINE_LEN;
                7:       n = $urandom_range(LINE_LEN + 1, 2 * LINE_LEN);
                8:       n = LINE_LEN - 1;
                default: n = LINE_LEN + 1;
            endcase
            steady = ($urandom_range(0, 3) == 0);
            send_text(n, $urandom_range(0, 1), $urandom_range(0, 1));
            sent += n;
            if (!drained && sent >= 30)
            begin
                drain_outputs();
                drained = 1'b1;
            end
        end
        steady = 1'b0;
    endtask

    // receiver: stall pattern switches mode now and then; check every transaction
    always @(posedge clk)
    begin
        stall_cycle++;
        if (stall_cycle % 97 == 0)
        begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0:       char_stall <= 1'b0;
            1:       char_stall <= ($urandom_range(0, 3) == 0);
            2:       char_stall <= ($urandom_range(0, 3) != 0);
            default: char_stall <= (stall_cycle % 3 == 0);
        endcase
        if (rst_n && char_valid && !char_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch("with nothing expected, out_char", out_char, -1);
            end
            else
            begin
                if (out_char !== expected_chars[0].ch)
                begin
                    report_mismatch("out_char", out_char, expected_chars[0].ch);
                end
                if (end_of_line !== expected_chars[0].eol)
                begin
                    report_mismatch("end_of_line", end_of_line, expected_chars[0].eol);
                end
                if (end_of_text !== expected_chars[0].eot)
                begin
                    report_mismatch("end_of_text", end_of_text, expected_chars[0].eot);
                end
                if (last_of_run !== expected_chars[0].last)
                begin
                    report_mismatch("last_of_run", last_of_run, expected_chars[0].last);
                end
                if (expected_chars[0].eol)
                begin
                    lines_seen++;
                end
                if (expected_chars[0].eot)
                begin
                    texts_ended++;
                end
                void'(expected_chars.pop_front());
            end
            chars_checked++;
        end
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d chars still expected", expected_chars.size());
        $display("** uuencode_line_encoder_core: FAILED **");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_terminator_only();
        test_short_lines();
        test_line_boundaries();
        test_random_texts();
        drain_outputs();
        repeat (20) @(posedge clk);
        $display("sent %0d input transactions, checked %0d chars", items_sent, chars_checked);
        $display("covered %0d encoded lines across %0d texts", lines_seen, texts_ended);
        if (mismatches == 0)
        begin
            $display("** uuencode_line_encoder_core: PASSED **");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("** uuencode_line_encoder_core: FAILED **");
        end
        $finish;
    end

endmodule
